// ----- sv/sha_pkg.sv -----
package sha_pkg;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } sha_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } sha_rsp_type;

   localparam logic REQ_ABSORB   = 1'b0;
   localparam logic REQ_FINALIZE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_START,
      ST_COMP,
      ST_EMIT
   } sha_state_type;

   // Byte source for the block buffer write
   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_PAD,
      SRC_ZERO,
      SRC_LEN
   } sha_src_type;

   typedef struct packed {
      logic        wr_en;
      sha_src_type wr_src;
      logic        fill_clear;
      logic        total_inc;
      logic        comp_start;
      logic        emit_next;
      logic        rearm;
   } sha_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       comp_done;
      logic [2:0] emit_index;
   } sha_status_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;

   function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
      ror32 = (v >> n) | (v << (32 - n));
   endfunction

endpackage

// ----- sv/sha_datapath.sv -----
module sha_datapath import sha_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  sha_cmd_type    cmd,
   input  logic [7:0]     data_byte,
   output sha_status_type status,
   output logic [31:0]    digest_word
);

   logic [5:0]  fill_ff, fill_in;
   logic [63:0] total_ff, total_in;
   logic [31:0] chain_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [6:0]  round_ff, round_in;
   logic        busy_ff, busy_in;
   logic [2:0]  emit_ff;
   logic [7:0]  wr_byte;
   logic [63:0] bit_len;
   logic [31:0] wi, s0, s1, t1, t2, e, a, w15, w2;

   assign bit_len = {total_ff[60:0], 3'b000};

   always_comb begin
      unique case (cmd.wr_src)
         SRC_DATA: wr_byte = data_byte;
         SRC_PAD:  wr_byte = PAD_BYTE;
         SRC_ZERO: wr_byte = 8'h00;
         SRC_LEN:  wr_byte = bit_len[8*(7 - fill_ff[2:0]) +: 8];
         default:  wr_byte = 8'h00;
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.fill_clear) begin
         fill_in = '0;
      end else if (cmd.wr_en) begin
         fill_in = fill_ff + 6'd1;
      end
      total_in = total_ff;
      if (cmd.rearm) begin
         total_in = '0;
      end else if (cmd.total_inc) begin
         total_in = total_ff + 64'd1;
      end
   end

   // Round datapath: the block window doubles as the rolling schedule, oldest word first
   assign w15 = w_ff[1];
   assign w2  = w_ff[14];
   assign s0  = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
   assign s1  = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
   assign wi  = (round_ff < 7'd16) ? w_ff[0] : w_ff[0] + s0 + w_ff[9] + s1;
   assign e   = v_ff[4];
   assign a   = v_ff[0];
   assign t1  = v_ff[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) +
                ((e & v_ff[5]) ^ (~e & v_ff[6])) + ROUND_K[round_ff[5:0]] + wi;
   assign t2  = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) +
                ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_comb begin
      busy_in  = busy_ff;
      round_in = round_ff;
      if (cmd.comp_start) begin
         busy_in  = 1'b1;
         round_in = '0;
      end else if (busy_ff) begin
         round_in = round_ff + 7'd1;
         if (round_ff == 7'd64) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         total_ff <= '0;
         busy_ff  <= 1'b0;
         round_ff <= '0;
         emit_ff  <= '0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= INIT_HASH[i];
      end else begin
         fill_ff  <= fill_in;
         total_ff <= total_in;
         busy_ff  <= busy_in;
         round_ff <= round_in;
         if (cmd.rearm) begin
            emit_ff <= '0;
            for (int i = 0; i < 8; i++) chain_ff[i] <= INIT_HASH[i];
         end else if (cmd.emit_next) begin
            emit_ff <= emit_ff + 3'd1;
         end
         if (busy_ff && round_ff == 7'd64) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         // shift the byte in at the tail of the block window
         for (int i = 0; i < 15; i++) w_ff[i] <= {w_ff[i][23:0], w_ff[i+1][31:24]};
         w_ff[15] <= {w_ff[15][23:0], wr_byte};
      end else if (busy_ff && round_ff != 7'd64) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wi;
      end
      if (cmd.comp_start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= chain_ff[i];
      end else if (busy_ff && round_ff != 7'd64) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   assign status.fill       = fill_ff;
   assign status.comp_done  = busy_ff && round_ff == 7'd64;
   assign status.emit_index = emit_ff;
   assign digest_word       = chain_ff[emit_ff];

endmodule

// ----- sv/sha_control.sv -----
module sha_control import sha_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  sha_req_type    req_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  sha_status_type status,
   output sha_cmd_type    cmd
);

   sha_state_type state_ff, state_in;
   logic          final_ff, final_in;
   logic          len_ff, len_in;
   logic          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         final_ff <= 1'b0;
         len_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
         len_ff   <= len_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      final_in  = final_ff;
      len_in    = len_ff;
      cmd       = '0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.wr_en = 1'b1;
               if (req_data.req_type == REQ_ABSORB) begin
                  cmd.wr_src    = SRC_DATA;
                  cmd.total_inc = 1'b1;
                  if (status.fill == 6'd63) begin
                     final_in = 1'b0;
                     state_in = ST_START;
                  end
               end else begin
                  cmd.wr_src = SRC_PAD;
                  final_in   = 1'b1;
                  if (status.fill == 6'd63) begin
                     state_in = ST_START;
                  end else begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_PAD: begin
            // zero fill up to the length field, or to the end of an overfull block
            cmd.wr_en = 1'b1;
            priority if (status.fill == LEN_START) begin
               cmd.wr_src = SRC_LEN;
               state_in   = ST_LEN;
            end else begin
               cmd.wr_src = SRC_ZERO;
               if (status.fill == 6'd63) begin
                  state_in = ST_START;
               end
            end
         end
         ST_LEN: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = SRC_LEN;
            if (status.fill == 6'd63) begin
               len_in   = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.comp_start = 1'b1;
            state_in       = ST_COMP;
         end
         ST_COMP: begin
            if (status.comp_done) begin
               priority if (!final_ff) begin
                  state_in = ST_IDLE;
               end else if (len_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.emit_index == 3'd7) begin
                  cmd.rearm      = 1'b1;
                  cmd.fill_clear = 1'b1;
                  final_in       = 1'b0;
                  len_in         = 1'b0;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- sv/sha256_byte_stream_hash_unit.sv -----
// Absorb: bytes are taken back to back while idle; the byte that fills a block
// stalls the input for a load, 64 rounds at one per cycle and a chain add.
// Finalize: pad, zero and length bytes one per cycle to the block end, a compression
// per block, a second block when fewer than 9 bytes remain, then eight digest words,
// one per cycle while the result side does not stall.
// Synchronous active-high reset loads the initial hash and clears counts.
module sha256_byte_stream_hash_unit import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  sha_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sha_rsp_type rsp_data
);

   sha_cmd_type    cmd;
   sha_status_type status;
   logic [31:0]    word;

   sha_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .status, .cmd(cmd)
   );

   sha_datapath u_dp (
      .clock, .reset, .cmd(cmd), .data_byte(req_data.data_byte),
      .status, .digest_word(word)
   );

   assign rsp_data.digest_word = word;
   assign rsp_data.word_index  = status.emit_index;
   assign rsp_data.last_word   = status.emit_index == 3'd7;

endmodule

// ----- sv/sha_checker.sv -----
module sha_checker import sha_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input sha_rsp_type rsp_data
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken during digest output");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled word changed");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == 3'd7)))
      else $error("last flag mismatch");

   a_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_word |=>
      rsp_valid && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1)
      else $error("word index skipped");

endmodule

bind sha256_byte_stream_hash_unit sha_checker u_chk (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);

// ----- dv/sha256_byte_stream_hash_unit_tb.sv -----
module sha256_byte_stream_hash_unit_tb;
   import sha_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   sha_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   sha_rsp_type rsp_data;

   sha256_byte_stream_hash_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   localparam int CYCLE_LIMIT = 400000;

   // predictor state
   logic [31:0] hash_chain [8];
   logic [7:0]  msg_block [64];
   int unsigned msg_fill;
   logic [63:0] msg_bytes;

   sha_rsp_type digest_q [$];
   int          fail_count;
   int          row_fails;
   int          cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   task automatic hash_rearm();
      for (int i = 0; i < 8; i++) hash_chain[i] = INIT_HASH[i];
      msg_fill  = 0;
      msg_bytes = '0;
   endtask

   task automatic compress_msg_block();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wi, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            wi = w[i];
         end else begin
            s0 = rotr(w[(i+1)%16], 7) ^ rotr(w[(i+1)%16], 18) ^ (w[(i+1)%16] >> 3);
            s1 = rotr(w[(i+14)%16], 17) ^ rotr(w[(i+14)%16], 19) ^ (w[(i+14)%16] >> 10);
            wi = w[i%16] + s0 + w[(i+9)%16] + s1;
            w[i%16] = wi;
         end
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + wi;
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_chain[i] += v[i];
   endtask

   task automatic predict_word(input sha_req_type r);
      logic [63:0] bit_len;
      sha_rsp_type d;
      if (r.req_type == REQ_ABSORB) begin
         msg_block[msg_fill] = r.data_byte;
         msg_fill++;
         msg_bytes++;
         if (msg_fill == 64) begin
            compress_msg_block();
            msg_fill = 0;
         end
      end else begin
         bit_len = msg_bytes << 3;
         msg_block[msg_fill] = PAD_BYTE;
         msg_fill++;
         if (msg_fill > 56) begin
            for (int i = msg_fill; i < 64; i++) msg_block[i] = 8'h00;
            compress_msg_block();
            msg_fill = 0;
         end
         for (int i = msg_fill; i < 56; i++) msg_block[i] = 8'h00;
         for (int i = 0; i < 8; i++) msg_block[63-i] = bit_len[8*i +: 8];
         compress_msg_block();
         for (int i = 0; i < 8; i++) begin
            d.digest_word = hash_chain[i];
            d.word_index  = 3'(i);
            d.last_word   = (i == 7);
            digest_q.push_back(d);
         end
         hash_rearm();
      end
   endtask

   // send one request, with a random gap in front; valid stays up until the next call
   task automatic send_word(input logic kind, input logic [7:0] b);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{req_type: kind, data_byte: b};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word('{req_type: kind, data_byte: b});
   endtask

   // directed rows: kind, byte, and the first digest word where it is well known
   typedef struct {
      logic        kind;
      logic [7:0]  b;
      logic        known;
      logic [31:0] word0;
   } stim_row_type;

   stim_row_type stim_rows [] = '{
      '{REQ_FINALIZE, 8'h00, 1'b1, 32'he3b0c442},  // empty message
      '{REQ_ABSORB,   8'h61, 1'b0, 32'h0},
      '{REQ_ABSORB,   8'h62, 1'b0, 32'h0},
      '{REQ_ABSORB,   8'h63, 1'b0, 32'h0},
      '{REQ_FINALIZE, 8'hff, 1'b1, 32'hba7816bf},  // "abc"
      '{REQ_ABSORB,   8'h00, 1'b0, 32'h0},
      '{REQ_ABSORB,   8'hff, 1'b0, 32'h0},
      '{REQ_ABSORB,   8'haa, 1'b0, 32'h0},
      '{REQ_ABSORB,   8'h55, 1'b0, 32'h0},
      '{REQ_FINALIZE, 8'h5a, 1'b0, 32'h0},
      '{REQ_FINALIZE, 8'h00, 1'b1, 32'he3b0c442}   // back-to-back finalize
   };

   // rsp side: random stall, checking against the oldest expectation
   always @(posedge clock) begin
      sha_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_q.size() == 0) begin
               $display("%0t: unexpected word %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = digest_q.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                           want.digest_word, want.word_index, want.last_word,
                           rsp_data.digest_word, rsp_data.word_index,
                           rsp_data.last_word);
                  fail_count++;
               end
            end
         end
         if (cycle_count % 600 < 150) rsp_stall <= 1'b0;
         else if ($urandom_range(0, 19) == 0) rsp_stall <= 1'b1;
         else if (rsp_stall && $urandom_range(0, 3) != 0 && $urandom_range(0, 9) != 0)
            rsp_stall <= $urandom_range(0, 1);
         else rsp_stall <= ($urandom_range(0, 5) == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sha256_byte_stream_hash_unit: mismatch");
         $finish;
      end
   end

   // check the predicted first digest word against the row's known word0 once it is queued
   task automatic run_rows();
      for (int i = 0; i < stim_rows.size(); i++) begin
         send_word(stim_rows[i].kind, stim_rows[i].b);
         if (stim_rows[i].known && digest_q.size() >= 8 &&
             digest_q[digest_q.size()-8].digest_word !== stim_rows[i].word0) begin
            $display("%0t: expected %h actual %h", $time, stim_rows[i].word0,
                     digest_q[digest_q.size()-8].digest_word);
            row_fails++;
         end
      end
   endtask

   initial begin
      int len;
      int sent;
      int drain;
      req_valid   = 1'b0;
      req_data    = '0;
      reset       = 1'b1;
      hash_rearm();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_rows();
      // messages of random length, many around the padding boundaries
      sent = 0;
      foreach (stim_rows[i]) sent++;
      len = 55;
      while (sent < 280) begin
         if (len > 279 - sent) len = 279 - sent;
         for (int k = 0; k < len; k++) send_word(REQ_ABSORB, 8'($urandom));
         send_word(REQ_FINALIZE, 8'($urandom));
         sent += len + 1;
         case ($urandom_range(0, 5))
            0: len = $urandom_range(55, 57);
            1: len = $urandom_range(63, 65);
            2: len = $urandom_range(119, 129);
            default: len = $urandom_range(0, 12);
         endcase
      end
      req_valid <= 1'b0;
      drain = 0;
      while (digest_q.size() != 0) @(posedge clock);
      while (drain < 300) begin
         @(posedge clock);
         drain++;
      end
      if (fail_count == 0 && row_fails == 0) $display("sha256_byte_stream_hash_unit: match");
      else $display("sha256_byte_stream_hash_unit: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/sha_pkg.sv
sv/sha_datapath.sv
sv/sha_control.sv
sv/sha256_byte_stream_hash_unit.sv
sv/sha_checker.sv
dv/sha256_byte_stream_hash_unit_tb.sv
